@@ rtl/a52_pkg.sv @@
// Package: shared types, constants and the microcode program of the A5/2 keystream cipher.
`timescale 1ns / 1ps

package a52_pkg;

  // Datapath operations selected by one control word
  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLEAR,
    DP_KEY,
    DP_FRAME,
    DP_MIX,
    DP_BIT
  } dp_op_e;

  // Sequencer branch conditions
  typedef enum logic [2:0] {
    SQ_DISPATCH,
    SQ_NEXT,
    SQ_LOOP,
    SQ_JUMP,
    SQ_PUSH
  } sq_cond_e;

  localparam int unsigned STEP_W = 3;
  localparam int unsigned CNT_W  = 7;

  typedef logic [STEP_W-1:0] step_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // One microcode word
  typedef struct packed {
    dp_op_e   op;
    sq_cond_e cond;
    step_t    target;
    cnt_t     cnt_val;
  } ucode_t;

  // Sequencer to datapath control
  typedef struct packed {
    dp_op_e op;
    logic   last;   // final pass of the current loop
    logic   load;   // request item accepted this cycle
  } dp_ctrl_t;

  // Loop lengths
  localparam int unsigned KEY_BITS   = 64;
  localparam int unsigned FRAME_BITS = 22;
  localparam int unsigned MIX_CLOCKS = 100;
  localparam int unsigned BYTE_BITS  = 8;

  // Program addresses
  localparam step_t STEP_IDLE    = 3'd0;
  localparam step_t STEP_CLEAR   = 3'd1;
  localparam step_t STEP_KEY     = 3'd2;
  localparam step_t STEP_FRAME   = 3'd3;
  localparam step_t STEP_MIX     = 3'd4;
  localparam step_t STEP_DISCARD = 3'd5;
  localparam step_t STEP_BYTE    = 3'd6;
  localparam step_t STEP_EMIT    = 3'd7;

  // LFSR feedback taps
  localparam logic [18:0] R1_TAPS = 19'h72000;
  localparam logic [21:0] R2_TAPS = 22'h300000;
  localparam logic [22:0] R3_TAPS = 23'h700080;
  localparam logic [16:0] R4_TAPS = 17'h10800;

  // Bits set by the last frame clock
  localparam logic [18:0] R1_FORCE = 19'h08000;
  localparam logic [21:0] R2_FORCE = 22'h010000;
  localparam logic [22:0] R3_FORCE = 23'h040000;
  localparam logic [16:0] R4_FORCE = 17'h00400;

  // Clock-control taps in R4
  localparam int unsigned R4_SEL1 = 10;
  localparam int unsigned R4_SEL2 = 3;
  localparam int unsigned R4_SEL3 = 7;

  function automatic logic maj3(input logic a, input logic b, input logic c);
    return (a & b) | (a & c) | (b & c);
  endfunction

  // Microcode program
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '{op: DP_NOP, cond: SQ_JUMP, target: STEP_IDLE, cnt_val: '0};
    case (step)
      STEP_IDLE: begin
        w = '{op: DP_NOP, cond: SQ_DISPATCH, target: STEP_BYTE,
              cnt_val: cnt_t'(BYTE_BITS - 1)};
      end
      STEP_CLEAR: begin
        w = '{op: DP_CLEAR, cond: SQ_NEXT, target: STEP_KEY,
              cnt_val: cnt_t'(KEY_BITS - 1)};
      end
      STEP_KEY: begin
        w = '{op: DP_KEY, cond: SQ_LOOP, target: STEP_KEY,
              cnt_val: cnt_t'(FRAME_BITS - 1)};
      end
      STEP_FRAME: begin
        w = '{op: DP_FRAME, cond: SQ_LOOP, target: STEP_FRAME,
              cnt_val: cnt_t'(MIX_CLOCKS - 1)};
      end
      STEP_MIX: begin
        w = '{op: DP_MIX, cond: SQ_LOOP, target: STEP_MIX, cnt_val: '0};
      end
      STEP_DISCARD: begin
        w = '{op: DP_BIT, cond: SQ_JUMP, target: STEP_IDLE, cnt_val: '0};
      end
      STEP_BYTE: begin
        w = '{op: DP_BIT, cond: SQ_LOOP, target: STEP_BYTE, cnt_val: '0};
      end
      STEP_EMIT: begin
        w = '{op: DP_NOP, cond: SQ_PUSH, target: STEP_IDLE, cnt_val: '0};
      end
      default: begin
        w = '{op: DP_NOP, cond: SQ_JUMP, target: STEP_IDLE, cnt_val: '0};
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/a52_if.sv @@
// Interfaces: request, result and key-write channels of the A5/2 keystream cipher.
`timescale 1ns / 1ps

interface a52_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [21:0] frame_number;
  logic [7:0]  data_byte;

  modport source (output valid, output req_type, output frame_number, output data_byte,
                  input ready);
  modport sink   (input valid, input req_type, input frame_number, input data_byte,
                  output ready);
endinterface

interface a52_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

interface a52_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] session_key;

  modport source (output valid, output session_key, input ready);
  modport sink   (input valid, input session_key, output ready);
endinterface

@@ rtl/a52_useq.sv @@
// Microcode sequencer: step counter, loop counter and branch logic over the program table.
`timescale 1ns / 1ps

module a52_useq
  import a52_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  logic     req_init_i,
  input  logic     out_free_i,
  output logic     req_ready_o,
  output logic     push_o,
  output dp_ctrl_t ctrl_o
);

  step_t  pc_q, pc_d;
  cnt_t   cnt_q, cnt_d;
  ucode_t cw;
  logic   fire;

  assign cw          = ucode_rom(pc_q);
  assign req_ready_o = (cw.cond == SQ_DISPATCH);
  assign fire        = req_valid_i && req_ready_o;

  // Control outputs of the current word
  assign ctrl_o.op   = cw.op;
  assign ctrl_o.last = (cnt_q == '0);
  assign ctrl_o.load = fire;
  assign push_o      = (cw.cond == SQ_PUSH) && out_free_i;

  // Next step and loop count
  always_comb begin
    pc_d  = pc_q;
    cnt_d = cnt_q;
    case (cw.cond)
      SQ_DISPATCH: begin
        cnt_d = cw.cnt_val;
        if (fire) begin
          pc_d = req_init_i ? STEP_CLEAR : cw.target;
        end
      end
      SQ_NEXT: begin
        cnt_d = cw.cnt_val;
        pc_d  = pc_q + step_t'(1);
      end
      SQ_LOOP: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - cnt_t'(1);
          pc_d  = cw.target;
        end else begin
          cnt_d = cw.cnt_val;
          pc_d  = pc_q + step_t'(1);
        end
      end
      SQ_JUMP: begin
        pc_d = cw.target;
      end
      SQ_PUSH: begin
        if (out_free_i) begin
          pc_d = cw.target;
        end
      end
      default: begin
        pc_d = STEP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= STEP_IDLE;
      cnt_q <= '0;
    end else begin
      pc_q  <= pc_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/a52_lfsr_dp.sv @@
// Datapath: the four LFSRs, delayed output bit, key and frame shifters and the byte register.
`timescale 1ns / 1ps

module a52_lfsr_dp
  import a52_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_ctrl_t    ctrl_i,
  input  logic [63:0] key_i,
  input  logic [21:0] frame_i,
  input  logic [7:0]  data_i,
  output logic [7:0]  byte_o
);

  logic [18:0] r1_q, r1_d, r1_sh;
  logic [21:0] r2_q, r2_d, r2_sh;
  logic [22:0] r3_q, r3_d, r3_sh;
  logic [16:0] r4_q, r4_d, r4_sh;
  logic        dly_q, dly_d;
  logic [63:0] key_sh_q, key_sh_d;
  logic [21:0] frm_sh_q, frm_sh_d;
  logic [7:0]  byte_q, byte_d;
  logic        c1, c2, c3, m;
  logic        frc, xb, ks;
  logic        m1, m2, m3;

  // One shift of each register with its feedback
  assign r1_sh = {r1_q[17:0], ^(r1_q & R1_TAPS)};
  assign r2_sh = {r2_q[20:0], ^(r2_q & R2_TAPS)};
  assign r3_sh = {r3_q[21:0], ^(r3_q & R3_TAPS)};
  assign r4_sh = {r4_q[15:0], ^(r4_q & R4_TAPS)};

  // Majority clock control from R4
  assign c1 = r4_q[R4_SEL1];
  assign c2 = r4_q[R4_SEL2];
  assign c3 = r4_q[R4_SEL3];
  assign m  = maj3(c1, c2, c3);

  // Forced-clock extras: force bits on the last frame clock, loaded bit
  assign frc = (ctrl_i.op == DP_FRAME) && ctrl_i.last;
  assign xb  = (ctrl_i.op == DP_KEY) ? key_sh_q[0] : frm_sh_q[0];

  // Next delayed bit
  assign m1 = maj3(r1_q[15], ~r1_q[14], r1_q[12]);
  assign m2 = maj3(~r2_q[16], r2_q[13], r2_q[9]);
  assign m3 = maj3(r3_q[18], r3_q[16], ~r3_q[13]);
  assign ks = dly_q;

  always_comb begin
    r1_d     = r1_q;
    r2_d     = r2_q;
    r3_d     = r3_q;
    r4_d     = r4_q;
    dly_d    = dly_q;
    key_sh_d = key_sh_q;
    frm_sh_d = ctrl_i.load ? frame_i : frm_sh_q;
    byte_d   = ctrl_i.load ? data_i : byte_q;
    case (ctrl_i.op)
      DP_CLEAR: begin
        r1_d     = '0;
        r2_d     = '0;
        r3_d     = '0;
        r4_d     = '0;
        dly_d    = 1'b0;
        key_sh_d = key_i;
      end
      DP_KEY, DP_FRAME: begin
        r1_d = (r1_sh | (R1_FORCE & {19{frc}})) ^ {18'b0, xb};
        r2_d = (r2_sh | (R2_FORCE & {22{frc}})) ^ {21'b0, xb};
        r3_d = (r3_sh | (R3_FORCE & {23{frc}})) ^ {22'b0, xb};
        r4_d = (r4_sh | (R4_FORCE & {17{frc}})) ^ {16'b0, xb};
        if (ctrl_i.op == DP_KEY) begin
          key_sh_d = {1'b0, key_sh_q[63:1]};
        end else begin
          frm_sh_d = {1'b0, frm_sh_q[21:1]};
        end
      end
      DP_MIX, DP_BIT: begin
        if (c1 == m) r1_d = r1_sh;
        if (c2 == m) r2_d = r2_sh;
        if (c3 == m) r3_d = r3_sh;
        r4_d = r4_sh;
        if (ctrl_i.op == DP_BIT) begin
          dly_d  = r1_q[18] ^ r2_q[21] ^ r3_q[22] ^ m1 ^ m2 ^ m3;
          // MSB first: rotate left, XOR keystream into the incoming bit
          byte_d = {byte_q[6:0], byte_q[7] ^ ks};
        end
      end
      default: begin
      end
    endcase
  end

  // Generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_q  <= '0;
      r2_q  <= '0;
      r3_q  <= '0;
      r4_q  <= '0;
      dly_q <= 1'b0;
    end else begin
      r1_q  <= r1_d;
      r2_q  <= r2_d;
      r3_q  <= r3_d;
      r4_q  <= r4_d;
      dly_q <= dly_d;
    end
  end

  // Payload shifters
  always_ff @(posedge clk_i) begin
    key_sh_q <= key_sh_d;
    frm_sh_q <= frm_sh_d;
    byte_q   <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

@@ rtl/a52_keystream_cipher.sv @@
// Top level: A5/2 keystream cipher with request, result and key-write channels.
`timescale 1ns / 1ps

// Usage:
//   cfg_i  - write the 64-bit session key (byte 0 in the low bits, used LSB
//            first). Always ready; write only while the block is idle. The key
//            is used at the next init item.
//   req_i  - one item per handshake. req_type 0: init with frame_number, no
//            result. req_type 1: XOR data_byte with the next eight keystream
//            bits, one result on rsp_o.
//   rsp_o  - out_byte, first keystream bit in the MSB.
// Timing: the microcode program runs one generator clock per cycle on its
//   key, frame, mixing and keystream steps. Data item: dispatch, 8 keystream
//   steps and the hand-off step, which pushes the result to rsp_o.
//   Init item: clear, 64 key clocks, 22 frame clocks, 100 mixing clocks and
//   one discarded bit, then back to the idle step.
// req_i.ready is high only on the program's idle step.
// Reset clears the key and all generator state; the program restarts at idle.
// A result held on a stalled rsp_o does not block a new item from being
// accepted; the program waits on its hand-off step only if the output
// register is still full when the next byte is done.

module a52_keystream_cipher
  import a52_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  a52_cfg_if.sink   cfg_i,
  a52_req_if.sink   req_i,
  a52_rsp_if.source rsp_o
);

  logic [63:0] key_q;
  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic [7:0]  dp_byte;
  logic        out_free;
  logic        push;
  dp_ctrl_t    ctrl;

  // Key register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_i.valid) begin
      key_q <= cfg_i.session_key;
    end
  end

  a52_useq u_useq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_init_i  (!req_i.req_type),
    .out_free_i  (out_free),
    .req_ready_o (req_i.ready),
    .push_o      (push),
    .ctrl_o      (ctrl)
  );

  a52_lfsr_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .key_i   (key_q),
    .frame_i (req_i.frame_number),
    .data_i  (req_i.data_byte),
    .byte_o  (dp_byte)
  );

  // Output register
  assign out_free = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_byte_q <= dp_byte;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.out_byte = out_byte_q;

endmodule

@@ tb/tb_top.sv @@
// Testbench: A5/2 keystream cipher checked against a bit-level keystream predictor.
`timescale 1ns / 1ps

module tb_top;

  // Generator constants, widths match the four registers
  localparam logic [18:0] R1_FB  = 19'h72000;
  localparam logic [21:0] R2_FB  = 22'h300000;
  localparam logic [22:0] R3_FB  = 23'h700080;
  localparam logic [16:0] R4_FB  = 17'h10800;
  localparam logic [18:0] R1_SET = 19'h08000;
  localparam logic [21:0] R2_SET = 22'h010000;
  localparam logic [22:0] R3_SET = 23'h040000;
  localparam logic [16:0] R4_SET = 17'h00400;

  localparam int unsigned SETTLE_CYCLES = 220;    // longer than one init run
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 150;
  localparam int unsigned NUM_PHASES    = 6;

  typedef enum logic {
    REQ_INIT = 1'b0,
    REQ_DATA = 1'b1
  } req_kind_e;

  // Keystream predictor plus queue of expected output bytes
  class keystream_scoreboard;
    logic [63:0] key;
    logic [18:0] r1;
    logic [21:0] r2;
    logic [22:0] r3;
    logic [16:0] r4;
    logic        dbit;
    logic [7:0]  expected_bytes[$];
    int unsigned errors;

    function new();
      key    = '0;
      r1     = '0;
      r2     = '0;
      r3     = '0;
      r4     = '0;
      dbit   = 1'b0;
      errors = 0;
    endfunction

    function logic maj(input logic a, input logic b, input logic c);
      return (a & b) | (a & c) | (b & c);
    endfunction

    // One generator clock; every forces all registers, load_force sets the fixed bits
    function void step_generator(input bit every, input bit load_force);
      logic c1, c2, c3, m;
      c1 = r4[10];
      c2 = r4[3];
      c3 = r4[7];
      m  = maj(c1, c2, c3);
      if (every || c1 == m) r1 = {r1[17:0], ^(r1 & R1_FB)} | (load_force ? R1_SET : '0);
      if (every || c2 == m) r2 = {r2[20:0], ^(r2 & R2_FB)} | (load_force ? R2_SET : '0);
      if (every || c3 == m) r3 = {r3[21:0], ^(r3 & R3_FB)} | (load_force ? R3_SET : '0);
      r4 = {r4[15:0], ^(r4 & R4_FB)} | (load_force ? R4_SET : '0);
    endfunction

    function void inject(input logic b);
      r1[0] = r1[0] ^ b;
      r2[0] = r2[0] ^ b;
      r3[0] = r3[0] ^ b;
      r4[0] = r4[0] ^ b;
    endfunction

    // Output is the delayed bit; the new one comes from the top bits and majorities
    function logic keystream_bit();
      logic now_bit, top;
      now_bit = dbit;
      top     = r1[18] ^ r2[21] ^ r3[22];
      dbit    = top ^ maj(r1[15], ~r1[14], r1[12]) ^ maj(~r2[16], r2[13], r2[9])
                ^ maj(r3[18], r3[16], ~r3[13]);
      step_generator(1'b0, 1'b0);
      return now_bit;
    endfunction

    function void run_setup(input logic [21:0] frame);
      r1   = '0;
      r2   = '0;
      r3   = '0;
      r4   = '0;
      dbit = 1'b0;
      for (int i = 0; i < 64; i++) begin
        step_generator(1'b1, 1'b0);
        inject(key[i]);
      end
      for (int i = 0; i < 22; i++) begin
        step_generator(1'b1, i == 21);
        inject(frame[i]);
      end
      for (int i = 0; i < 100; i++) begin
        step_generator(1'b0, 1'b0);
      end
      void'(keystream_bit());
    endfunction

    function void set_key(input logic [63:0] k);
      key = k;
    endfunction

    function void note_request(input req_kind_e kind, input logic [21:0] frame,
                               input logic [7:0] data);
      logic [7:0] res;
      if (kind == REQ_INIT) begin
        run_setup(frame);
      end else begin
        for (int k = 7; k >= 0; k--) begin
          res[k] = data[k] ^ keystream_bit();
        end
        expected_bytes.push_back(res);
      end
    endfunction

    function void check_result(input logic [7:0] got);
      logic [7:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: out_byte=%h", got);
        return;
      end
      want = expected_bytes.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("out_byte mismatch: expected %h, got %h", want, got);
      end
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  a52_cfg_if cfg_bus ();
  a52_req_if req_bus ();
  a52_rsp_if rsp_bus ();

  a52_keystream_cipher dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_bus),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  keystream_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          hold_off_req;
  int unsigned cycle_count;

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned hold_left;
    stall_left    = 0;
    hold_left     = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        sb.check_result(rsp_bus.out_byte);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(1, 19) - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // Offer one item, with an optional idle burst first; returns at the accepting edge
  task automatic send_item(input req_kind_e kind, input logic [21:0] frame,
                           input logic [7:0] data);
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 19);
    end
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.req_type     <= kind;
    req_bus.frame_number <= frame;
    req_bus.data_byte    <= data;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    sb.note_request(kind, frame, data);
  endtask

  task automatic send_random(input int unsigned init_pct);
    req_kind_e kind;
    kind = ($urandom_range(0, 99) < init_pct) ? REQ_INIT : REQ_DATA;
    send_item(kind, 22'($urandom()), 8'($urandom()));
  endtask

  // Wait until every result is in and any init run has finished
  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_key(input logic [63:0] k);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.session_key <= k;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    cfg_bus.valid <= 1'b0;
    sb.set_key(k);
  endtask

  // Main sequence
  initial begin
    logic [63:0] phase_key;
    int unsigned send_pct[NUM_PHASES];
    int unsigned recv_pct[NUM_PHASES];

    send_pct             = '{25, 0, 50, 10, 30, 0};
    recv_pct             = '{25, 0, 50, 40, 10, 0};
    rst_n                = 1'b0;
    hold_off_req         = 1'b0;
    send_idle_pct        = 15;
    recv_idle_pct        = 15;
    cfg_bus.valid        <= 1'b0;
    cfg_bus.session_key  <= '0;
    req_bus.valid        <= 1'b0;
    req_bus.req_type     <= REQ_INIT;
    req_bus.frame_number <= '0;
    req_bus.data_byte    <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Encrypt before any init runs from the all-zero state
    send_item(REQ_DATA, 22'h000000, 8'h00);
    send_item(REQ_DATA, 22'h3FFFFF, 8'hFF);
    send_item(REQ_DATA, 22'h000000, 8'h5A);
    drain();

    // Zero key and frame
    write_key(64'h0);
    send_item(REQ_INIT, 22'h000000, 8'h00);
    send_item(REQ_DATA, 22'h000000, 8'h00);
    send_item(REQ_DATA, 22'h000000, 8'hFF);
    drain();

    // All-ones key and frame
    write_key('1);
    send_item(REQ_INIT, 22'h3FFFFF, 8'hFF);
    send_item(REQ_DATA, 22'h3FFFFF, 8'h00);
    send_item(REQ_DATA, 22'h3FFFFF, 8'hFF);
    send_item(REQ_DATA, 22'h000000, 8'h80);
    send_item(REQ_DATA, 22'h000000, 8'h01);
    drain();

    // Mixed key, then init twice in a row
    write_key(64'h0123_4567_89AB_CDEF);
    send_item(REQ_INIT, 22'h000134, 8'h00);
    send_item(REQ_DATA, 22'h000000, 8'h3C);
    send_item(REQ_INIT, 22'h2AAAAA, 8'h00);
    send_item(REQ_INIT, 22'h155555, 8'h00);
    send_item(REQ_DATA, 22'h000000, 8'hC3);
    send_item(REQ_DATA, 22'h000000, 8'hAA);
    drain();

    // New key only takes effect at the next init
    write_key(64'h8000_0000_0000_0001);
    send_item(REQ_DATA, 22'h000000, 8'h55);
    send_item(REQ_DATA, 22'h000000, 8'h0F);
    send_item(REQ_INIT, 22'h000001, 8'h00);
    send_item(REQ_DATA, 22'h000000, 8'hF0);

    // Random phases: each opens with an init, then mostly data with some re-inits
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      case (p)
        1:       phase_key = '0;
        2:       phase_key = '1;
        3:       phase_key = 64'h1 << $urandom_range(0, 63);
        default: phase_key = {$urandom(), $urandom()};
      endcase
      write_key(phase_key);
      send_idle_pct = send_pct[p];
      recv_idle_pct = recv_pct[p];
      send_item(REQ_INIT, 22'($urandom()), 8'($urandom()));
      for (int i = 1; i < PHASE_ITEMS; i++) begin
        // back-pressure: result side holds off while data keeps coming
        if (p == 1 && i == 5) hold_off_req = 1'b1;
        send_random((p == 1 && i < 60) ? 0 : 12);
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ a52_keystream_cipher.f @@
rtl/a52_pkg.sv
rtl/a52_if.sv
rtl/a52_useq.sv
rtl/a52_lfsr_dp.sv
rtl/a52_keystream_cipher.sv
tb/tb_top.sv
